/* design/tms_pkg.sv */
// Shared types and constants of the tone and melody sequencer.
// Depends on nothing; every other design file except tms_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package tms_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned HZ_W    = 16;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned ENTRY_W = HZ_W + MS_W;

  // Melody notes go quiet for the last 1/(2**SILENT_SHIFT) of their length.
  localparam int unsigned SILENT_SHIFT = 3;

  localparam int unsigned DEF_MELODY_DEPTH = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_TONE  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_PLAY  = 3'd3,
    CMD_STOP  = 3'd4
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } ctrl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic exec;      // apply the accepted item
    logic walk;      // one step of the note table walk
    logic load_out;  // capture the result fields
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_walk;  // the item being applied starts a table walk
    logic walk_done;  // this walk step is the last one
  } dp_status_t;

endpackage

`default_nettype wire

/* design/tms_if.sv */
// Valid/ready channel interfaces for items and results of the sequencer.
// Depends on tms_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tms_item_if;
  import tms_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [HZ_W-1:0]  note_hz;
  logic [MS_W-1:0]  note_ms;
  logic [IDX_W-1:0] note_index;
  logic [CNT_W-1:0] melody_count;

  modport source (output valid, cmd, note_hz, note_ms, note_index, melody_count,
                  input ready);
  modport sink   (input valid, cmd, note_hz, note_ms, note_index, melody_count,
                  output ready);
endinterface

interface tms_result_if;
  import tms_pkg::*;

  logic            valid;
  logic            ready;
  logic [HZ_W-1:0] drive_hz;
  logic            sounding;
  logic            playing;

  modport source (output valid, drive_hz, sounding, playing, input ready);
  modport sink   (input valid, drive_hz, sounding, playing, output ready);
endinterface

`default_nettype wire

/* design/tone_melody_sequencer_core.sv */
// Top level of the buzzer tone and melody sequencer.
// Depends on tms_pkg, tms_if, tms_ram, tms_ctrl and tms_dp.
//
//   channel  dir  transfer on           payload
//   -------  ---  --------------------  -----------------------------------------------
//   item     in   item.valid & ready    cmd, note_hz, note_ms, note_index, melody_count
//   result   out  result.valid & ready  drive_hz, sounding, playing
//
// Steps: tick, tone, write note, stop and unknown commands go from transfer
//   to the result load in ST_EMIT. A play, or a tick that ends a note, also walks
//   the note table through the single read port: it primes the read, examines
//   the entries in turn and stops at the first entry with a length or at the
//   end of the melody.
// One item is in flight at a time; the next is taken once its result is registered.
// Reset (rst, synchronous) clears playback state; the note table is not cleared.
// A stalled result holds in the output register; a new item may transfer
//   meanwhile, and its result waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module tone_melody_sequencer_core #(
  parameter int unsigned MELODY_DEPTH = tms_pkg::DEF_MELODY_DEPTH
) (
  input wire logic     clk,
  input wire logic     rst,
  tms_item_if.sink     item,
  tms_result_if.source result
);
  import tms_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Controller: owns both handshakes and sequences exec, walk and result load.
  tms_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item.valid),
    .item_ready  (item.ready),
    .result_valid(result.valid),
    .result_ready(result.ready),
    .status      (status),
    .cmd         (cmd)
  );

  // Datapath: playback state, note table and the registered result fields.
  tms_dp #(
    .MELODY_DEPTH(MELODY_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .item_cmd    (item.cmd),
    .note_hz     (item.note_hz),
    .note_ms     (item.note_ms),
    .note_index  (item.note_index),
    .melody_count(item.melody_count),
    .drive_hz    (result.drive_hz),
    .sounding    (result.sounding),
    .playing     (result.playing)
  );

endmodule

`default_nettype wire

/* design/tms_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tms_ram #(
  parameter  int unsigned WIDTH  = 32,
  parameter  int unsigned DEPTH  = 64,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/tms_ctrl.sv */
// Controller of the sequencer: item/result handshakes and the step sequence.
// Depends on tms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tms_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  output logic                     result_valid,
  input  wire logic                result_ready,
  input  wire tms_pkg::dp_status_t status,
  output tms_pkg::ctrl_cmd_t       cmd
);
  import tms_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_free;

  assign out_free = !result_valid || result_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = status.need_walk ? ST_WALK : ST_EMIT;
        end
      end
      ST_WALK: begin
        if (status.walk_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready   = 1'b0;
    cmd.exec     = 1'b0;
    cmd.walk     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        cmd.exec   = item_valid;
      end
      ST_WALK: cmd.walk = 1'b1;
      ST_EMIT: cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/tms_dp.sv */
// Datapath of the sequencer: playback state, note table and result fields.
// Depends on tms_pkg and tms_ram.
`timescale 1ns / 1ps
`default_nettype none

module tms_dp #(
  parameter int unsigned MELODY_DEPTH = tms_pkg::DEF_MELODY_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tms_pkg::ctrl_cmd_t          cmd,
  output tms_pkg::dp_status_t              status,
  input  wire logic [tms_pkg::CMD_W-1:0]   item_cmd,
  input  wire logic [tms_pkg::HZ_W-1:0]    note_hz,
  input  wire logic [tms_pkg::MS_W-1:0]    note_ms,
  input  wire logic [tms_pkg::IDX_W-1:0]   note_index,
  input  wire logic [tms_pkg::CNT_W-1:0]   melody_count,
  output logic      [tms_pkg::HZ_W-1:0]    drive_hz,
  output logic                             sounding,
  output logic                             playing
);
  import tms_pkg::*;

  localparam int unsigned ADDR_W  = (MELODY_DEPTH > 1) ? $clog2(MELODY_DEPTH) : 1;
  localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
  localparam int unsigned CLAMP   = (MELODY_DEPTH < CNT_MAX) ? MELODY_DEPTH : CNT_MAX;
  localparam logic [CNT_W-1:0] CLAMP_V = CNT_W'(CLAMP);

  // Playback state.
  logic [CNT_W-1:0] note_total, note_total_next;
  logic [CNT_W-1:0] next_entry, next_entry_next;
  logic [MS_W-1:0]  elapsed_ms, elapsed_ms_next;
  logic [MS_W-1:0]  current_length, current_length_next;
  logic [HZ_W-1:0]  current_hz, current_hz_next;
  logic             is_playing, is_playing_next;
  logic             is_sounding, is_sounding_next;
  logic             melody_active, melody_active_next;
  logic             table_changed, table_changed_next;
  logic             rd_vld, rd_vld_next;

  // Table port.
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [HZ_W-1:0]    rd_hz;
  logic [MS_W-1:0]    rd_ms;

  logic [MS_W-1:0]  elapsed_inc;
  logic [MS_W-1:0]  silent_at;
  logic [CNT_W-1:0] count_clamped;
  logic [CNT_W-1:0] next_inc;
  logic             index_ok;
  logic             same_melody;

  assign rd_hz = ram_rdata[ENTRY_W-1:MS_W];
  assign rd_ms = ram_rdata[MS_W-1:0];

  assign elapsed_inc   = (elapsed_ms == '1) ? elapsed_ms : elapsed_ms + MS_W'(1);
  assign silent_at     = current_length - (current_length >> SILENT_SHIFT);
  assign count_clamped = (melody_count > CLAMP_V) ? CLAMP_V : melody_count;
  assign next_inc      = next_entry + CNT_W'(1);
  assign index_ok      = 32'(note_index) < MELODY_DEPTH;
  assign same_melody   = (count_clamped != '0) && melody_active && !table_changed &&
                         (count_clamped == note_total);

  assign ram_waddr = ADDR_W'(note_index);
  assign ram_raddr = ADDR_W'(rd_vld ? next_inc : next_entry);

  always_comb begin
    note_total_next     = note_total;
    next_entry_next     = next_entry;
    elapsed_ms_next     = elapsed_ms;
    current_length_next = current_length;
    current_hz_next     = current_hz;
    is_playing_next     = is_playing;
    is_sounding_next    = is_sounding;
    melody_active_next  = melody_active;
    table_changed_next  = table_changed;
    rd_vld_next         = rd_vld;
    ram_we              = 1'b0;
    status.need_walk    = 1'b0;
    status.walk_done    = 1'b0;

    if (cmd.walk) begin
      if (next_entry >= note_total) begin
        // end of the melody
        status.walk_done   = 1'b1;
        melody_active_next = 1'b0;
        is_playing_next    = 1'b0;
        is_sounding_next   = 1'b0;
      end else if (!rd_vld) begin
        rd_vld_next = 1'b1;
      end else begin
        next_entry_next = next_inc;
        if (rd_ms != '0) begin
          status.walk_done    = 1'b1;
          current_hz_next     = rd_hz;
          current_length_next = rd_ms;
          is_playing_next     = 1'b1;
          is_sounding_next    = (rd_hz != '0);
          elapsed_ms_next     = '0;
        end
      end
    end else begin
      unique case (item_cmd)
        CMD_TICK: begin
          if (is_playing) begin
            elapsed_ms_next = elapsed_inc;
            if (melody_active && is_sounding && elapsed_inc >= silent_at) begin
              is_sounding_next = 1'b0;
            end
            if (current_length != '0 && elapsed_inc >= current_length) begin
              status.need_walk = 1'b1;
              rd_vld_next      = 1'b0;
            end
          end
        end
        CMD_TONE: begin
          if (is_playing && !melody_active && note_hz == current_hz &&
              note_ms == current_length) begin
            // same tone already running: ignore
          end else if (note_hz == '0 && note_ms == '0) begin
            melody_active_next = 1'b0;
            is_playing_next    = 1'b0;
            is_sounding_next   = 1'b0;
          end else begin
            melody_active_next  = 1'b0;
            current_hz_next     = note_hz;
            current_length_next = note_ms;
            is_playing_next     = 1'b1;
            is_sounding_next    = (note_hz != '0);
            elapsed_ms_next     = '0;
          end
        end
        CMD_WRITE: begin
          if (index_ok) begin
            ram_we             = cmd.exec;
            table_changed_next = 1'b1;
          end
        end
        CMD_PLAY: begin
          if (!(is_playing && same_melody)) begin
            status.need_walk   = 1'b1;
            note_total_next    = count_clamped;
            melody_active_next = (count_clamped != '0);
            table_changed_next = 1'b0;
            next_entry_next    = '0;
            rd_vld_next        = 1'b0;
          end
        end
        CMD_STOP: begin
          melody_active_next = 1'b0;
          is_playing_next    = 1'b0;
          is_sounding_next   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      note_total     <= '0;
      next_entry     <= '0;
      elapsed_ms     <= '0;
      current_length <= '0;
      current_hz     <= '0;
      is_playing     <= 1'b0;
      is_sounding    <= 1'b0;
      melody_active  <= 1'b0;
      table_changed  <= 1'b1;
      rd_vld         <= 1'b0;
    end else if (cmd.exec || cmd.walk) begin
      note_total     <= note_total_next;
      next_entry     <= next_entry_next;
      elapsed_ms     <= elapsed_ms_next;
      current_length <= current_length_next;
      current_hz     <= current_hz_next;
      is_playing     <= is_playing_next;
      is_sounding    <= is_sounding_next;
      melody_active  <= melody_active_next;
      table_changed  <= table_changed_next;
      rd_vld         <= rd_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      drive_hz <= is_playing ? current_hz : '0;
      sounding <= is_sounding;
      playing  <= is_playing;
    end
  end

  tms_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MELODY_DEPTH)
  ) u_notes (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({note_hz, note_ms}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  a_sound_needs_play: assert property (@(posedge clk) disable iff (rst)
    is_sounding |-> is_playing)
    else $error("tone audible while playback is off");

  // a play marks the melody active before its walk has found the first note
  a_melody_needs_play: assert property (@(posedge clk) disable iff (rst)
    melody_active && !cmd.walk |-> is_playing)
    else $error("melody marked active while playback is off");

  a_walk_in_bounds: assert property (@(posedge clk) disable iff (rst)
    next_entry <= note_total)
    else $error("table walk ran past the melody length");

  a_walk_rearms_read: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && status.need_walk |=> !rd_vld)
    else $error("table walk started with a stale read");

endmodule

`default_nettype wire

/* tb/tms_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the tone and melody sequencer: predicts each result and compares.
// Depends on tms_pkg and the channel interfaces in tms_if.
module tms_checker #(
  parameter int unsigned MELODY_DEPTH = tms_pkg::DEF_MELODY_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  tms_item_if         item,
  tms_result_if       result,
  output int unsigned fail_count,
  output int unsigned pending_count
);
  import tms_pkg::*;

  typedef struct packed {
    logic [HZ_W-1:0] drive_hz;
    logic            sounding;
    logic            playing;
  } buzzer_out_t;

  logic [ENTRY_W-1:0] note_table [MELODY_DEPTH];
  logic [CNT_W-1:0]   melody_len;
  logic [CNT_W-1:0]   read_ptr;
  logic [MS_W-1:0]    ms_elapsed;
  logic [MS_W-1:0]    note_len;
  logic [HZ_W-1:0]    note_freq;
  logic               busy;
  logic               audible;
  logic               in_melody;
  logic               table_dirty;

  buzzer_out_t expected_out [$];
  int unsigned mismatches = 0;
  int unsigned pending    = 0;

  assign fail_count    = mismatches;
  assign pending_count = pending;

  initial begin
    foreach (note_table[i]) note_table[i] = '0;
  end

  function automatic void begin_sound(logic [HZ_W-1:0] hz, logic [MS_W-1:0] ms);
    note_freq = hz;
    note_len  = ms;
    busy      = 1'b1;
    audible   = (hz != '0);
  endfunction

  function automatic void go_quiet();
    in_melody = 1'b0;
    busy      = 1'b0;
    audible   = 1'b0;
  endfunction

  // Start the next table entry with a length; zero-length entries are skipped.
  function automatic bit next_melody_note();
    logic [ENTRY_W-1:0] entry;
    while (read_ptr < melody_len && read_ptr < MELODY_DEPTH) begin
      entry = note_table[read_ptr];
      read_ptr++;
      if (entry[MS_W-1:0] != '0) begin
        begin_sound(entry[ENTRY_W-1:MS_W], entry[MS_W-1:0]);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic buzzer_out_t apply_item(logic [CMD_W-1:0] op, logic [HZ_W-1:0] hz,
                                             logic [MS_W-1:0] ms, logic [IDX_W-1:0] idx,
                                             logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] span;
    bit               same_melody;
    buzzer_out_t      r;
    case (op)
      CMD_TICK: begin
        if (busy) begin
          if (ms_elapsed != '1) ms_elapsed++;
          // melody notes go quiet for the last eighth of their length
          if (in_melody && audible && ms_elapsed >= note_len - (note_len >> SILENT_SHIFT))
            audible = 1'b0;
          if (note_len != '0 && ms_elapsed >= note_len) begin
            if (next_melody_note()) ms_elapsed = '0;
            else go_quiet();
          end
        end
      end
      CMD_TONE: begin
        if (!(busy && !in_melody && hz == note_freq && ms == note_len)) begin
          if (hz == '0 && ms == '0) begin
            go_quiet();
          end else begin
            in_melody  = 1'b0;
            begin_sound(hz, ms);
            ms_elapsed = '0;
          end
        end
      end
      CMD_WRITE: begin
        if (idx < MELODY_DEPTH) begin
          note_table[idx] = {hz, ms};
          table_dirty     = 1'b1;
        end
      end
      CMD_PLAY: begin
        span = (cnt > MELODY_DEPTH) ? CNT_W'(MELODY_DEPTH) : cnt;
        same_melody = busy && span != '0 && in_melody && !table_dirty && span == melody_len;
        if (!same_melody) begin
          melody_len  = span;
          in_melody   = (span != '0);
          table_dirty = 1'b0;
          read_ptr    = '0;
          if (next_melody_note()) ms_elapsed = '0;
          else go_quiet();
        end
      end
      CMD_STOP: go_quiet();
      default: ;
    endcase
    r.drive_hz = busy ? note_freq : '0;
    r.sounding = audible;
    r.playing  = busy;
    return r;
  endfunction

  always @(posedge clk) begin : score
    buzzer_out_t got;
    buzzer_out_t want;
    if (rst) begin
      expected_out.delete();
      melody_len  = '0;
      read_ptr    = '0;
      ms_elapsed  = '0;
      note_len    = '0;
      note_freq   = '0;
      busy        = 1'b0;
      audible     = 1'b0;
      in_melody   = 1'b0;
      table_dirty = 1'b1;
    end else begin
      // a result never belongs to the item taken at the same edge, so check first
      if (result.valid && result.ready) begin
        got.drive_hz = result.drive_hz;
        got.sounding = result.sounding;
        got.playing  = result.playing;
        if (expected_out.size() == 0) begin
          mismatches++;
          $error("result transfer with no result expected: drive_hz %0d", got.drive_hz);
        end else begin
          want = expected_out.pop_front();
          if (got.drive_hz !== want.drive_hz) begin
            mismatches++;
            $error("drive_hz: expected %0d, got %0d", want.drive_hz, got.drive_hz);
          end
          if (got.sounding !== want.sounding) begin
            mismatches++;
            $error("sounding: expected %0b, got %0b", want.sounding, got.sounding);
          end
          if (got.playing !== want.playing) begin
            mismatches++;
            $error("playing: expected %0b, got %0b", want.playing, got.playing);
          end
        end
      end
      if (item.valid && item.ready)
        expected_out.push_back(apply_item(item.cmd, item.note_hz, item.note_ms,
                                          item.note_index, item.melody_count));
    end
    pending <= expected_out.size();
  end

endmodule

/* tb/tone_melody_sequencer_core_tb.sv */
`timescale 1ns / 1ps
// Top of the sequencer testbench: clock, reset, stimulus, handshake pacing and verdict.
// Depends on tms_pkg, tms_if, tone_melody_sequencer_core and tms_checker.
module tone_melody_sequencer_core_tb;
  import tms_pkg::*;

  localparam int unsigned DEPTH        = DEF_MELODY_DEPTH;
  localparam int unsigned ITEM_TARGET  = 650;
  // Slowest item is a full table walk plus idle gaps on each side; STALL_LIMIT
  // allows many times that before calling the run hung.
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = DEPTH + 16;
  localparam int unsigned MAX_COUNT    = (1 << CNT_W) - 1;

  // Command codes the block does not decode.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  logic clk;
  logic rst;

  tms_item_if   item ();
  tms_result_if result ();

  int unsigned fail_count;
  int unsigned pending_count;

  // Table bookkeeping: a play may only reach entries that hold data, so track
  // the run of written entries starting at entry 0.
  bit               written [DEPTH];
  int unsigned      written_run = 0;
  int unsigned      items_sent  = 0;
  bit               no_idle     = 1'b0;
  logic [HZ_W-1:0]  last_hz     = '0;
  logic [MS_W-1:0]  last_ms     = '0;
  logic [CNT_W-1:0] last_count  = '0;

  tone_melody_sequencer_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result)
  );

  tms_checker #(.MELODY_DEPTH(DEPTH)) score (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .result        (result),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Frequencies: rests and the all-ones value show up often, the rest is uniform.
  function automatic logic [HZ_W-1:0] rand_hz();
    int unsigned pct;
    pct = $urandom_range(0, 99);
    if (pct < 15) return '0;
    if (pct < 25) return '1;
    return HZ_W'($urandom_range(0, 65535));
  endfunction

  // Melody note lengths: mostly short so notes expire within a few ticks.
  function automatic logic [MS_W-1:0] rand_note_ms();
    int unsigned pct;
    pct = $urandom_range(0, 99);
    if (pct < 10) return '0;
    if (pct < 75) return MS_W'($urandom_range(1, 6));
    if (pct < 90) return MS_W'($urandom_range(7, 40));
    return MS_W'($urandom_range(0, 65535));
  endfunction

  // Tone lengths: endless, short, or anything.
  function automatic logic [MS_W-1:0] rand_tone_ms();
    int unsigned pct;
    pct = $urandom_range(0, 99);
    if (pct < 30) return '0;
    if (pct < 80) return MS_W'($urandom_range(1, 10));
    return MS_W'($urandom_range(0, 65535));
  endfunction

  // Don't-care fields: ms and index over their full range, counts up to the depth.
  function automatic logic [MS_W-1:0] rand_ms_any();
    return MS_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [IDX_W-1:0] rand_idx_any();
    return IDX_W'($urandom_range(0, DEPTH - 1));
  endfunction

  function automatic logic [CNT_W-1:0] rand_cnt_any();
    return CNT_W'($urandom_range(0, DEPTH));
  endfunction

  // Favor extending the written run; otherwise overwrite inside it or hit any entry.
  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned pct;
    pct = $urandom_range(0, 99);
    if (written_run < DEPTH && pct < 55) return IDX_W'(written_run);
    if (written_run > 0 && pct < 85) return IDX_W'($urandom_range(0, written_run - 1));
    return rand_idx_any();
  endfunction

  // Never reach past the written run; counts above the depth only once it is full.
  function automatic logic [CNT_W-1:0] pick_count();
    int unsigned pct;
    pct = $urandom_range(0, 99);
    if (written_run == 0 || pct < 5) return '0;
    if (written_run == DEPTH && pct < 12)
      return CNT_W'($urandom_range(DEPTH + 1, MAX_COUNT));
    if (pct < 70) return CNT_W'($urandom_range(1, (written_run < 6) ? written_run : 6));
    return CNT_W'($urandom_range(1, written_run));
  endfunction

  // Present one item and hold it until the transfer. Drop valid only when an idle
  // gap follows, so valid sees one assignment per time step.
  task automatic send_item(input logic [CMD_W-1:0] op, input logic [HZ_W-1:0] hz,
                           input logic [MS_W-1:0] ms, input logic [IDX_W-1:0] idx,
                           input logic [CNT_W-1:0] cnt);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.valid        <= 1'b1;
    item.cmd          <= op;
    item.note_hz      <= hz;
    item.note_ms      <= ms;
    item.note_index   <= idx;
    item.melody_count <= cnt;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    items_sent++;
    if (op == CMD_WRITE) begin
      written[idx] = 1'b1;
      while (written_run < DEPTH && written[written_run]) written_run++;
    end
  endtask

  // Fields a command ignores still carry random values to toggle every bit.
  task automatic send_ticks(input int unsigned n);
    repeat (n)
      send_item(CMD_TICK, rand_hz(), rand_ms_any(), rand_idx_any(), rand_cnt_any());
  endtask

  task automatic send_tone(input logic [HZ_W-1:0] hz, input logic [MS_W-1:0] ms);
    last_hz = hz;
    last_ms = ms;
    send_item(CMD_TONE, hz, ms, rand_idx_any(), rand_cnt_any());
  endtask

  task automatic write_note(input logic [IDX_W-1:0] idx, input logic [HZ_W-1:0] hz,
                            input logic [MS_W-1:0] ms);
    send_item(CMD_WRITE, hz, ms, idx, rand_cnt_any());
  endtask

  task automatic send_play(input logic [CNT_W-1:0] cnt);
    last_count = cnt;
    send_item(CMD_PLAY, rand_hz(), rand_ms_any(), rand_idx_any(), cnt);
  endtask

  task automatic send_stop();
    send_item(CMD_STOP, rand_hz(), rand_ms_any(), rand_idx_any(), rand_cnt_any());
  endtask

  // Result side: stall a random number of cycles before each result, none in a burst.
  initial begin : result_pacing
    int unsigned stall;
    result.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      @(posedge clk);
      while (!result.valid) @(posedge clk);
    end
  end

  // Abort when neither channel has moved a transfer for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (item.valid && item.ready) || (result.valid && result.ready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned roll;
    int unsigned steps;
    rst               <= 1'b1;
    item.valid        <= 1'b0;
    item.cmd          <= CMD_TICK;
    item.note_hz      <= '0;
    item.note_ms      <= '0;
    item.note_index   <= '0;
    item.melody_count <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: idle tick, endless and repeated tone, extreme values, timed
    // rest, a tone that runs out, rest of zero length as stop, spare commands.
    send_ticks(1);
    send_tone(16'd440, 16'd0);
    send_ticks(1);
    send_tone(16'd440, 16'd0);
    send_tone(16'hFFFF, 16'hFFFF);
    send_tone(16'd0, 16'd5);
    send_tone(16'd1000, 16'd2);
    send_ticks(2);
    send_tone(16'd300, 16'd4);
    send_tone(16'd0, 16'd0);
    send_item(CMD_SPARE_LO, 16'hFFFF, 16'hFFFF, 6'd63, 7'd64);
    send_item(CMD_SPARE_HI, 16'h0000, 16'h0000, 6'd0, 7'd0);
    send_stop();

    // Melody with nothing but zero-length notes, then an empty count.
    write_note(6'd0, 16'h1234, 16'd0);
    write_note(6'd1, 16'h5555, 16'd0);
    write_note(6'd63, 16'hAAAA, 16'hFFFF);
    send_play(7'd2);
    send_play(7'd0);

    // Real melody: a note, a skipped entry, a short rest; replay is ignored,
    // the note goes quiet near its end, and a write lands mid-playback.
    write_note(6'd0, 16'hFFFF, 16'd3);
    write_note(6'd2, 16'd0, 16'd1);
    send_play(7'd3);
    send_play(7'd3);
    send_ticks(3);
    write_note(6'd2, 16'h00FF, 16'd2);
    send_ticks(1);

    // Random part, built mostly from well-formed melody and tone sequences.
    while (items_sent < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 99) < 20);
      pick    = $urandom_range(0, 99);
      if (pick < 45) begin
        // load a few notes, play, then walk the melody on ticks with occasional
        // table writes, replays and stops mixed in
        repeat ($urandom_range(1, 4)) write_note(pick_index(), rand_hz(), rand_note_ms());
        send_play(pick_count());
        steps = $urandom_range(3, 25);
        repeat (steps) begin
          roll = $urandom_range(0, 99);
          if (roll < 4) write_note(pick_index(), rand_hz(), rand_note_ms());
          else if (roll < 7) send_play(last_count);
          else if (roll < 9) send_stop();
          else send_ticks(1);
        end
      end else if (pick < 75) begin
        send_tone(rand_hz(), rand_tone_ms());
        if ($urandom_range(0, 99) < 40) send_tone(last_hz, last_ms);
        send_ticks($urandom_range(0, 12));
        if ($urandom_range(0, 99) < 15) send_tone(16'd0, 16'd0);
      end else begin
        // single stray commands
        roll = $urandom_range(0, 99);
        if (roll < 30) send_ticks(1);
        else if (roll < 45) send_stop();
        else if (roll < 60) send_tone(rand_hz(), rand_ms_any());
        else if (roll < 75) write_note(rand_idx_any(), rand_hz(), rand_note_ms());
        else if (roll < 90) send_play(pick_count());
        else if (roll < 95) send_tone(16'd0, 16'd0);
        else
          send_item(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), rand_hz(),
                    rand_ms_any(), rand_idx_any(), rand_cnt_any());
      end
    end
    no_idle = 1'b0;
    item.valid <= 1'b0;

    // Let the last expectation register, drain every result, then hold a while
    // longer so a stray extra result would still be caught.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
